// ===== rtl/lots_pkg.sv =====
// shared types and constants for the letter order sort core
// no dependencies
package lots_pkg;

  localparam int ALPHA    = 26;
  localparam int LET_W    = 5;
  localparam int WORD_LEN = 64;
  localparam int WPOS_W   = 6;
  localparam int WLEN_W   = 7;
  localparam int Q_DEPTH  = 4;
  localparam int Q_PTR_W  = 2;
  localparam int Q_CNT_W  = 3;
  localparam int LIST_AW  = 2 * LET_W;

  typedef logic [LET_W-1:0] letter_t;

  typedef enum logic [1:0] {
    K_LETTER = 2'd0,
    K_EOW    = 2'd1,
    K_EOS    = 2'd2,
    K_NONE   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LETTER,
    S_EOW,
    S_EOS
  } s1_op_t;

  // one queue word: an edge, or the end-of-set marker
  typedef struct packed {
    logic    is_end;
    logic    seen;
    letter_t a;
    letter_t b;
  } qent_t;

  typedef struct packed {
    logic nearly_full;
    logic empty;
  } qstat_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_INS,
    B_CMP,
    B_ROOT,
    B_EXP,
    B_EDGE,
    B_ONE,
    B_EMIT,
    B_CLEAR
  } bstate_t;

endpackage

// ===== rtl/letter_order_topological_sort_core.sv =====
// top level of the letter order sort core: front, queue and back
// depends on lots_pkg, lots_front, lots_queue, lots_back
//
//   channel  ports                         handshake
//   input    in_kind, in_letter            in_push / in_full
//   result   out_letter_res, out_last      out_pop / out_empty
//
// letters and word ends are taken one per cycle while the edge queue has room
// each edge insert scans its successor list
// a set end with edges runs the walk: a root scan, a depth-first expansion of
// each root, then the results in reverse finish order and a clearing state;
// input keeps filling the queue meanwhile
// synchronous active-low reset, no clearing pass
module letter_order_topological_sort_core import lots_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_push,
  output logic             in_full,
  input  logic [1:0]       in_kind,
  input  logic [LET_W-1:0] in_letter,
  output logic             out_empty,
  input  logic             out_pop,
  output logic [LET_W-1:0] out_letter_res,
  output logic             out_last
);

  qstat_t q_stat;
  logic   q_push;
  qent_t  q_data;
  logic   q_pop;
  qent_t  q_head;

  lots_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_kind   (in_kind),
    .in_letter (in_letter),
    .in_full   (in_full),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_data    (q_data)
  );

  lots_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_data),
    .pop       (q_pop),
    .head      (q_head),
    .stat      (q_stat)
  );

  lots_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_head         (q_head),
    .q_stat         (q_stat),
    .q_pop          (q_pop),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_letter_res (out_letter_res),
    .out_last       (out_last)
  );

endmodule

// ===== rtl/lots_front.sv =====
// front end: word buffers, letter compare and edge generation
// depends on lots_pkg
module lots_front import lots_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_push,
  input  logic [1:0]       in_kind,
  input  logic [LET_W-1:0] in_letter,
  output logic             in_full,
  input  qstat_t           q_stat,
  output logic             q_push,
  output qent_t            q_data
);

  letter_t               word_mem [2*WORD_LEN];
  letter_t               prev_rd_r;
  logic [WLEN_W-1:0]     cur_len_r;
  logic [WLEN_W-1:0]     prev_len_r;
  logic                  bank_r;
  logic                  seen_r;
  logic                  diff_r;
  s1_op_t                s1_op_r;
  s1_op_t                s1_op_nxt;
  letter_t               s1_letter_r;
  logic                  s1_check_r;
  logic                  s1_seen_r;
  letter_t               s1_first_r;
  letter_t               cur_first_r;
  letter_t               prev_first_r;
  logic                  acc;
  logic                  let_ok;
  logic                  wr_en;
  logic [WPOS_W:0]       wr_addr;
  logic [WPOS_W:0]       rd_addr;
  kind_t                 kind;

  assign kind    = kind_t'(in_kind);
  assign in_full = q_stat.nearly_full;
  assign acc     = in_push && !in_full;
  assign let_ok  = (in_letter < LET_W'(ALPHA)) && (cur_len_r < WLEN_W'(WORD_LEN));
  assign wr_en   = acc && (kind == K_LETTER) && let_ok;
  assign wr_addr = {bank_r, cur_len_r[WPOS_W-1:0]};
  assign rd_addr = {~bank_r, cur_len_r[WPOS_W-1:0]};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      word_mem[wr_addr] <= in_letter;
      prev_rd_r <= word_mem[rd_addr];
    end
  end

  always_comb begin
    s1_op_nxt = S_IDLE;
    if (acc) begin
      case (kind)
        K_LETTER: begin
          if (let_ok) s1_op_nxt = S_LETTER;
        end
        K_EOW: begin
          if (cur_len_r != '0) s1_op_nxt = S_EOW;
        end
        K_EOS: s1_op_nxt = S_EOS;
        default: s1_op_nxt = S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_len_r  <= '0;
      prev_len_r <= '0;
      bank_r     <= 1'b0;
      seen_r     <= 1'b0;
      diff_r     <= 1'b0;
      s1_op_r    <= S_IDLE;
      s1_check_r <= 1'b0;
    end else begin
      s1_op_r <= s1_op_nxt;
      if (acc) begin
        case (kind)
          K_LETTER: begin
            if (let_ok) begin
              s1_letter_r <= in_letter;
              s1_check_r  <= seen_r && (cur_len_r < prev_len_r);
              cur_len_r   <= cur_len_r + WLEN_W'(1);
              if (cur_len_r == '0) begin
                cur_first_r <= in_letter;
              end
            end
          end
          K_EOW: begin
            if (cur_len_r != '0) begin
              bank_r       <= ~bank_r;
              prev_len_r   <= cur_len_r;
              cur_len_r    <= '0;
              seen_r       <= 1'b1;
              prev_first_r <= cur_first_r;
            end
          end
          K_EOS: begin
            s1_seen_r  <= seen_r;
            s1_first_r <= prev_first_r;
            cur_len_r  <= '0;
            prev_len_r <= '0;
            seen_r     <= 1'b0;
          end
          default: begin
          end
        endcase
      end
      case (s1_op_r)
        S_LETTER: begin
          if (s1_check_r && (prev_rd_r != s1_letter_r)) begin
            diff_r <= 1'b1;
          end
        end
        S_EOW, S_EOS: diff_r <= 1'b0;
        default: begin
        end
      endcase
    end
  end

  assign q_push = ((s1_op_r == S_LETTER) && s1_check_r && !diff_r &&
                   (prev_rd_r != s1_letter_r)) || (s1_op_r == S_EOS);

  always_comb begin
    q_data.is_end = (s1_op_r == S_EOS);
    q_data.seen   = s1_seen_r;
    q_data.a      = (s1_op_r == S_EOS) ? s1_first_r : prev_rd_r;
    q_data.b      = s1_letter_r;
  end

endmodule

// ===== rtl/lots_queue.sv =====
// short queue of edge and end-of-set words between front and back
// depends on lots_pkg
module lots_queue import lots_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  qent_t  push_data,
  input  logic   pop,
  output qent_t  head,
  output qstat_t stat
);

  qent_t              ent_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wp_r;
  logic [Q_PTR_W-1:0] rp_r;
  logic [Q_CNT_W-1:0] cnt_r;
  logic               do_pop;

  assign do_pop           = pop && (cnt_r != '0);
  assign head             = ent_r[rp_r];
  assign stat.empty       = (cnt_r == '0);
  assign stat.nearly_full = (cnt_r >= Q_CNT_W'(Q_DEPTH - 1));

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + Q_PTR_W'(1);
      end
      if (do_pop) begin
        rp_r <= rp_r + Q_PTR_W'(1);
      end
      cnt_r <= cnt_r + Q_CNT_W'(push) - Q_CNT_W'(do_pop);
    end
  end

endmodule

// ===== rtl/lots_back.sv =====
// back end: successor lists, depth-first walk and result register
// depends on lots_pkg
module lots_back import lots_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  qent_t            q_head,
  input  qstat_t           q_stat,
  output logic             q_pop,
  output logic             out_empty,
  input  logic             out_pop,
  output logic [LET_W-1:0] out_letter_res,
  output logic             out_last
);

  bstate_t                 state_r;
  bstate_t                 state_nxt;
  letter_t                 list_mem [2**LIST_AW];
  letter_t                 list_rd_r;
  letter_t                 cnt_r [ALPHA];
  logic [ALPHA-1:0]        used_r;
  logic [ALPHA-1:0]        visited_r;
  letter_t                 from_r;
  letter_t                 to_r;
  logic [LET_W-1:0]        i_r;
  letter_t                 first_r;
  logic [LET_W-1:0]        root_r;
  letter_t                 u_r;
  logic [LET_W-1:0]        idx_r;
  logic [LET_W-1:0]        sp_r;
  logic [LET_W-1:0]        fcnt_r;
  logic [2*LET_W-1:0]      stk_r [ALPHA];
  letter_t                 fin_r [ALPHA];
  logic                    ov_r;
  letter_t                 ol_r;
  logic                    olast_r;
  logic                    slot_free;
  logic                    ov_set;
  logic                    list_we;
  logic                    list_re;
  logic [LIST_AW-1:0]      list_waddr;
  logic [LIST_AW-1:0]      list_raddr;
  letter_t                 n_from;
  letter_t                 n_u;
  logic                    root_hit;
  logic                    v_new;

  assign slot_free = !ov_r || out_pop;
  assign ov_set    = ((state_r == B_ONE) || (state_r == B_EMIT)) && slot_free;
  assign n_from    = cnt_r[from_r];
  assign n_u       = cnt_r[u_r];
  assign root_hit  = used_r[root_r] && !visited_r[root_r];
  assign v_new     = !visited_r[list_rd_r] && (sp_r < LET_W'(ALPHA));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE: begin
        if (!q_stat.empty) begin
          if (!q_head.is_end) state_nxt = B_INS;
          else if (!q_head.seen) state_nxt = B_CLEAR;
          else if (used_r == '0) state_nxt = B_ONE;
          else state_nxt = B_ROOT;
        end
      end
      B_INS:   state_nxt = (i_r == n_from) ? B_IDLE : B_CMP;
      B_CMP:   state_nxt = (list_rd_r == to_r) ? B_IDLE : B_INS;
      B_ROOT: begin
        if (root_r == LET_W'(ALPHA)) state_nxt = B_EMIT;
        else if (root_hit) state_nxt = B_EXP;
      end
      B_EXP: begin
        if (idx_r < n_u) state_nxt = B_EDGE;
        else if (sp_r == LET_W'(1)) state_nxt = B_ROOT;
      end
      B_EDGE:  state_nxt = B_EXP;
      B_ONE:   if (slot_free) state_nxt = B_CLEAR;
      B_EMIT:  if (slot_free && (fcnt_r == LET_W'(1))) state_nxt = B_CLEAR;
      B_CLEAR: state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    q_pop      = (state_r == B_IDLE) && !q_stat.empty;
    list_we    = (state_r == B_INS) && (i_r == n_from) && (n_from < LET_W'(ALPHA));
    list_waddr = {from_r, n_from};
    list_re    = ((state_r == B_INS) && (i_r != n_from)) ||
                 ((state_r == B_EXP) && (idx_r < n_u));
    list_raddr = (state_r == B_INS) ? {from_r, i_r} : {u_r, idx_r};
  end

  always_ff @(posedge clk) begin
    if (list_we) begin
      list_mem[list_waddr] <= to_r;
    end
    if (list_re) begin
      list_rd_r <= list_mem[list_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= B_IDLE;
      used_r    <= '0;
      visited_r <= '0;
      ov_r      <= 1'b0;
      sp_r      <= '0;
      fcnt_r    <= '0;
      root_r    <= '0;
      for (int k = 0; k < ALPHA; k++) begin
        cnt_r[k] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_set || (ov_r && !out_pop);
      case (state_r)
        B_IDLE: begin
          if (!q_stat.empty) begin
            from_r  <= q_head.a;
            to_r    <= q_head.b;
            first_r <= q_head.a;
            i_r     <= '0;
            root_r  <= '0;
            sp_r    <= '0;
            fcnt_r  <= '0;
          end
        end
        B_INS: begin
          if (i_r == n_from) begin
            if (n_from < LET_W'(ALPHA)) begin
              cnt_r[from_r] <= n_from + LET_W'(1);
            end
            used_r <= used_r | (ALPHA'(1) << from_r) | (ALPHA'(1) << to_r);
          end
        end
        B_CMP: i_r <= i_r + LET_W'(1);
        B_ROOT: begin
          if (root_r != LET_W'(ALPHA)) begin
            if (root_hit) begin
              visited_r <= visited_r | (ALPHA'(1) << root_r);
              u_r       <= root_r;
              idx_r     <= '0;
              sp_r      <= LET_W'(1);
            end else begin
              root_r <= root_r + LET_W'(1);
            end
          end
        end
        B_EXP: begin
          if (idx_r < n_u) begin
            idx_r <= idx_r + LET_W'(1);
          end else begin
            if (fcnt_r < LET_W'(ALPHA)) begin
              fin_r[fcnt_r] <= u_r;
              fcnt_r        <= fcnt_r + LET_W'(1);
            end
            sp_r <= sp_r - LET_W'(1);
            if (sp_r != LET_W'(1)) begin
              {u_r, idx_r} <= stk_r[sp_r - LET_W'(2)];
            end
          end
        end
        B_EDGE: begin
          if (v_new) begin
            visited_r            <= visited_r | (ALPHA'(1) << list_rd_r);
            stk_r[sp_r - LET_W'(1)] <= {u_r, idx_r};
            u_r                  <= list_rd_r;
            idx_r                <= '0;
            sp_r                 <= sp_r + LET_W'(1);
          end
        end
        B_ONE: begin
          if (slot_free) begin
            ol_r    <= first_r;
            olast_r <= 1'b1;
          end
        end
        B_EMIT: begin
          if (slot_free) begin
            ol_r    <= fin_r[fcnt_r - LET_W'(1)];
            olast_r <= (fcnt_r == LET_W'(1));
            fcnt_r  <= fcnt_r - LET_W'(1);
          end
        end
        B_CLEAR: begin
          used_r    <= '0;
          visited_r <= '0;
          for (int k = 0; k < ALPHA; k++) begin
            cnt_r[k] <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign out_empty      = !ov_r;
  assign out_letter_res = ol_r;
  assign out_last       = olast_r;

  a_visited_used: assert property (@(posedge clk) disable iff (!rst_n)
    (visited_r & ~used_r) == '0)
    else $error("visited letter not in use");

  a_exp_sp: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_EXP || state_r == B_EDGE) |-> (sp_r != '0))
    else $error("walk step with empty stack");

  a_emit_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == B_EMIT |-> (fcnt_r != '0))
    else $error("emit with no finished letter");

  a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= LET_W'(ALPHA))
    else $error("walk stack overflow");

endmodule
